@@ sv/interarrival_jitter_stats_core_macros.svh @@
// Assertion macros shared by the interarrival jitter statistics RTL.
`ifndef INTERARRIVAL_JITTER_STATS_CORE_MACROS_SVH
`define INTERARRIVAL_JITTER_STATS_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define IJS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define IJS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ijs_pkg.sv @@
// Shared types and constants for the interarrival jitter statistics block.
`timescale 1ns / 1ps

package ijs_pkg;

  localparam int TS_W      = 64;
  localparam int CNT_W     = 32;
  localparam int IV_W      = 32;
  localparam int FRAC_BITS = 4;
  localparam int FIX_W     = IV_W + FRAC_BITS;
  localparam int JIT_SHIFT = 4;
  localparam int LO_W      = IV_W + CNT_W + 1;
  localparam int SUM_W     = FIX_W + CNT_W + 1;
  localparam int DIV_STEPS = FIX_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [TS_W-1:0]  recv_time_ns;
    logic [CNT_W-1:0] count_for_average;
  } ijs_in_t;

  typedef struct packed {
    logic             stats_valid;
    logic [IV_W-1:0]  last_interval;
    logic [FIX_W-1:0] average_interval;
    logic [IV_W-1:0]  min_interval;
    logic [IV_W-1:0]  max_interval;
    logic [FIX_W-1:0] jitter_estimate;
  } ijs_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic calc_iv;
    logic mul_lo;
    logic mul_hi;
    logic div_load;
    logic div_step;
    logic div_last;
    logic out_load;
  } ijs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic armed;
    logic out_free;
  } ijs_status_t;

endpackage

@@ sv/interarrival_jitter_stats_core.sv @@
// Top level of the interarrival jitter statistics block.
//
//   Channel | Ports                          | Carries
//   --------+--------------------------------+-------------------------------------
//   input   | in_valid, in_stall, in_data    | receive timestamp and averaging count
//   output  | out_valid, out_stall, out_data | interval, average, min, max, jitter
//
// A measured request passes these steps from acceptance to its result being registered:
// interval, low and high multiply, a sum, 36 restoring divide steps and the result load.
// An arming request goes from the interval step straight to the result load.
// One request is in flight at a time; the next is taken in the cycle after the result load.
// A stalled output holds the result register; the next request is still accepted, but its result load waits for it.
// Reset clears the timestamp (unarmed), average, jitter, maximum and sets minimum to ones.
`timescale 1ns / 1ps
`include "interarrival_jitter_stats_core_macros.svh"

module interarrival_jitter_stats_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ijs_pkg::ijs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ijs_pkg::ijs_out_t out_data
);
  import ijs_pkg::*;

  ijs_cmd_t    cmd;
  ijs_status_t st;

  ijs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ijs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `IJS_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall, "request accepted while busy")
  `IJS_ASSERT_IMP(a_min_last_max, out_valid && out_data.stats_valid, out_data.min_interval <= out_data.last_interval && out_data.last_interval <= out_data.max_interval, "interval outside min/max")
  `IJS_ASSERT_IMP(a_avg_bound, out_valid, out_data.average_interval[FIX_W-1:FRAC_BITS] <= out_data.max_interval, "average above maximum")

endmodule

@@ sv/ijs_ctrl.sv @@
// Sequencing state machine for the interarrival jitter statistics block.
`timescale 1ns / 1ps

module ijs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ijs_pkg::ijs_status_t st,
  output ijs_pkg::ijs_cmd_t    cmd
);
  import ijs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INTV  = 7'b0000010,
    S_MULLO = 7'b0000100,
    S_MULHI = 7'b0001000,
    S_ADD   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } ijs_state_t;

  ijs_state_t           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_INTV;
        end
      end
      S_INTV: begin
        cmd.calc_iv = 1'b1;
        state_nxt   = st.armed ? S_MULLO : S_OUT;
      end
      S_MULLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MULHI;
      end
      S_MULHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          cmd.div_last = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ sv/ijs_dp.sv @@
// Datapath: interval, min/max, jitter, running average divider and result register.
`timescale 1ns / 1ps

module ijs_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ijs_pkg::ijs_in_t     in_data,
  input  ijs_pkg::ijs_cmd_t    cmd,
  output ijs_pkg::ijs_status_t st,
  input  logic                 out_stall,
  output logic                 out_valid,
  output ijs_pkg::ijs_out_t    out_data
);
  import ijs_pkg::*;

  // Architectural state.
  logic [TS_W-1:0]  prev_r;
  logic [FIX_W-1:0] avg_r;
  logic [IV_W-1:0]  min_r;
  logic [IV_W-1:0]  max_r;
  logic [FIX_W-1:0] jit_r;
  logic [IV_W-1:0]  iv_r;
  logic             out_valid_r;

  // Working registers for the request in flight.
  logic [TS_W-1:0]  time_r;
  logic [CNT_W-1:0] n_r;
  logic             meas_r;
  logic [FIX_W-1:0] dev_r;
  logic [LO_W-1:0]  lo_r;
  logic [FIX_W-1:0] hi_r;
  logic [CNT_W-1:0] rem_r;
  logic [FIX_W-1:0] quo_r;
  ijs_out_t         out_data_r;

  logic [TS_W-1:0]  diff_w;
  logic [IV_W-1:0]  iv_nxt;
  logic [FIX_W-1:0] x_w;
  logic [FIX_W-1:0] dev_nxt;
  logic [FIX_W-1:0] jit_nxt;
  logic [FIX_W:0]   down_w;
  logic [CNT_W-1:0] m_w;
  logic [2*CNT_W-1:0] plo_w;
  logic [FIX_W-1:0] phi_w;
  logic [SUM_W-1:0] sum_w;
  logic [CNT_W:0]   trial_w;
  logic             ge_w;
  logic [FIX_W-1:0] quo_nxt;

  assign st.armed    = (prev_r != '0);
  assign st.out_free = !out_valid_r || !out_stall;

  // A timestamp that goes backwards gives a zero interval; large gaps saturate.
  assign diff_w = time_r - prev_r;
  always_comb begin
    if (time_r < prev_r) begin
      iv_nxt = '0;
    end else if (diff_w[TS_W-1:IV_W] != '0) begin
      iv_nxt = '1;
    end else begin
      iv_nxt = diff_w[IV_W-1:0];
    end
  end

  assign x_w     = {iv_r, {FRAC_BITS{1'b0}}};
  assign dev_nxt = (x_w >= jit_r) ? (x_w - jit_r) : (jit_r - x_w);

  // The downward step rounds toward minus infinity, so it is a ceiling of the magnitude.
  assign down_w = {1'b0, jit_r - dev_r} + (FIX_W + 1)'((1 << JIT_SHIFT) - 1);
  always_comb begin
    if (dev_r >= jit_r) begin
      jit_nxt = jit_r + ((dev_r - jit_r) >> JIT_SHIFT);
    end else begin
      jit_nxt = jit_r - FIX_W'(down_w >> JIT_SHIFT);
    end
  end

  assign m_w   = n_r - 1'b1;
  assign plo_w = (2*CNT_W)'(avg_r[IV_W-1:0]) * (2*CNT_W)'(m_w);
  assign phi_w = FIX_W'(avg_r[FIX_W-1:IV_W]) * FIX_W'(m_w);
  assign sum_w = SUM_W'({hi_r, {IV_W{1'b0}}}) + SUM_W'(lo_r);

  // Restoring division; the partial remainder always stays below n.
  assign trial_w = {rem_r, quo_r[FIX_W-1]};
  assign ge_w    = (trial_w >= {1'b0, n_r});
  assign quo_nxt = {quo_r[FIX_W-2:0], ge_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      avg_r       <= '0;
      min_r       <= '1;
      max_r       <= '0;
      jit_r       <= '0;
      iv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.calc_iv) begin
        prev_r <= time_r;
        if (st.armed) begin
          iv_r <= iv_nxt;
        end
      end
      if (cmd.mul_lo) begin
        if (iv_r < min_r) begin
          min_r <= iv_r;
        end
        if (iv_r > max_r) begin
          max_r <= iv_r;
        end
      end
      if (cmd.mul_hi) begin
        jit_r <= jit_nxt;
      end
      if (cmd.div_last) begin
        avg_r <= quo_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      time_r <= in_data.recv_time_ns;
      n_r    <= (in_data.count_for_average == '0) ? CNT_W'(1) : in_data.count_for_average;
    end
    if (cmd.calc_iv) begin
      meas_r <= st.armed;
    end
    if (cmd.mul_lo) begin
      dev_r <= dev_nxt;
      lo_r  <= LO_W'(plo_w);
    end
    if (cmd.mul_hi) begin
      hi_r <= phi_w;
      lo_r <= lo_r + LO_W'(x_w);
    end
    if (cmd.div_load) begin
      rem_r <= sum_w[SUM_W-2:FIX_W];
      quo_r <= sum_w[FIX_W-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= ge_w ? CNT_W'(trial_w - {1'b0, n_r}) : trial_w[CNT_W-1:0];
      quo_r <= quo_nxt;
    end
    if (cmd.out_load) begin
      out_data_r.stats_valid      <= meas_r;
      out_data_r.last_interval    <= iv_r;
      out_data_r.average_interval <= avg_r;
      out_data_r.min_interval     <= min_r;
      out_data_r.max_interval     <= max_r;
      out_data_r.jitter_estimate  <= jit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the interarrival jitter statistics core.
`timescale 1ns / 1ps

module tb;
  import ijs_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 60;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  ijs_in_t   in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ijs_out_t  out_data;

  // Predicted state of the statistics engine.
  logic [TS_W-1:0]  prev_ts;
  logic [FIX_W-1:0] avg_fix;
  logic [IV_W-1:0]  min_iv;
  logic [IV_W-1:0]  max_iv;
  logic [FIX_W-1:0] jit_fix;
  logic [IV_W-1:0]  last_iv;

  ijs_out_t   pending_stats[$];
  ijs_out_t   want_stats;
  int         err_count = 0;
  int         cycle_count = 0;
  int         out_hold_left = 0;
  bit         in_gaps_on = 1'b0;
  bit         out_gaps_on = 1'b0;
  logic [TS_W-1:0] stamp;

  interarrival_jitter_stats_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side back-pressure in bursts.
  always @(posedge clk) begin
    if (out_hold_left != 0) begin
      out_hold_left <= out_hold_left - 1;
      out_stall     <= 1'b1;
    end else if (out_gaps_on && $urandom_range(0, 9) == 0) begin
      out_hold_left <= $urandom_range(0, 12);
      out_stall     <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        err_count = err_count + 1;
        if (err_count <= 10)
          $display("ERROR: result with no request pending: %p", out_data);
      end else begin
        want_stats = pending_stats.pop_front();
        if (out_data !== want_stats) begin
          err_count = err_count + 1;
          if (err_count <= 10)
            $display({"ERROR: stats mismatch\n  valid exp %b got %b\n",
                      "  last  exp %h got %h\n  avg   exp %h got %h\n",
                      "  min   exp %h got %h\n  max   exp %h got %h\n",
                      "  jit   exp %h got %h"},
                     want_stats.stats_valid, out_data.stats_valid,
                     want_stats.last_interval, out_data.last_interval,
                     want_stats.average_interval, out_data.average_interval,
                     want_stats.min_interval, out_data.min_interval,
                     want_stats.max_interval, out_data.max_interval,
                     want_stats.jitter_estimate, out_data.jitter_estimate);
        end
      end
    end
  end

  function automatic ijs_out_t next_interval_stats(ijs_in_t req);
    logic [TS_W-1:0]  diff;
    logic [IV_W-1:0]  iv;
    logic [CNT_W-1:0] n;
    logic [FIX_W-1:0] x;
    logic [FIX_W-1:0] dev;
    logic [FIX_W:0]   gap;
    logic [127:0]     sum;
    ijs_out_t         res;
    res.stats_valid = 1'b0;
    if (prev_ts == '0) begin
      prev_ts = req.recv_time_ns;
    end else begin
      diff = (req.recv_time_ns >= prev_ts) ? req.recv_time_ns - prev_ts : '0;
      iv = (diff > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[IV_W-1:0];
      x = {iv, 4'b0000};
      prev_ts = req.recv_time_ns;
      last_iv = iv;
      n = (req.count_for_average == '0) ? 32'd1 : req.count_for_average;
      // Full-width product so that large counts do not wrap.
      sum = 128'(avg_fix) * 128'(n - 32'd1) + 128'(x);
      sum = sum / 128'(n);
      avg_fix = sum[FIX_W-1:0];
      if (iv < min_iv) min_iv = iv;
      if (iv > max_iv) max_iv = iv;
      dev = (x >= jit_fix) ? x - jit_fix : jit_fix - x;
      // The downward step rounds toward minus infinity, as a floor shift does.
      if (dev >= jit_fix) begin
        gap = {1'b0, dev - jit_fix};
        jit_fix = jit_fix + FIX_W'(gap >> JIT_SHIFT);
      end else begin
        gap = {1'b0, jit_fix - dev} + 37'd15;
        jit_fix = jit_fix - FIX_W'(gap >> JIT_SHIFT);
      end
      res.stats_valid = 1'b1;
    end
    res.last_interval    = last_iv;
    res.average_interval = avg_fix;
    res.min_interval     = min_iv;
    res.max_interval     = max_iv;
    res.jitter_estimate  = jit_fix;
    return res;
  endfunction

  task automatic send_request(input logic [TS_W-1:0] ts, input logic [CNT_W-1:0] cnt);
    ijs_in_t req;
    req.recv_time_ns      = ts;
    req.count_for_average = cnt;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pending_stats.push_back(next_interval_stats(req));
    stamp = ts;
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic test_arming_and_zero();
    send_request(64'd0, 32'd5);
    send_request(64'd0, 32'd0);
    send_request(64'd1000, 32'd0);
    send_request(64'd1000, 32'd0);
    send_request(64'd1500, 32'd1);
    send_request(64'd1400, 32'd2);
    send_request(64'd0, 32'd7);
    send_request(64'd250, 32'd3);
    send_request(64'd260, 32'd3);
  endtask

  task automatic test_interval_extremes();
    send_request(stamp + 64'hFFFF_FFFF, 32'd4);
    send_request(stamp + 64'h1_0000_0000, 32'd4);
    send_request(stamp + 64'h2_0000_0000, 32'hFFFF_FFFF);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    send_request(64'd0, 32'd1);
    send_request(64'hFFFF_FFFF_FFFF_FFF0, 32'hFFFF_FFFF);
    send_request(64'hFFFF_FFFF_FFFF_FFF7, 32'd0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFE);
    send_request(64'h5555_5555_5555_5555, 32'h5555_5555);
    send_request(64'h5555_5556_5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic send_random_packets(input int total);
    logic [TS_W-1:0]  ts;
    logic [CNT_W-1:0] cnt;
    int               pick;
    int               run_left;
    run_left = 0;
    for (int i = 0; i < total; i++) begin
      // Each run starts from a fresh base so every timestamp bit moves.
      if (run_left == 0) begin
        run_left = $urandom_range(10, 60);
        ts = {$urandom, $urandom} >> $urandom_range(0, 40);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      ts = stamp + $urandom_range(1, 5000);
        else if (pick < 80) ts = stamp + $urandom;
        else if (pick < 85) ts = stamp + {$urandom, $urandom};
        else if (pick < 90) ts = stamp - $urandom_range(1, 100000);
        else if (pick < 93) ts = '0;
        else                ts = stamp;
      end
      run_left = run_left - 1;
      pick = $urandom_range(0, 99);
      if (pick < 50)      cnt = $urandom_range(1, 32);
      else if (pick < 65) cnt = '0;
      else if (pick < 85) cnt = $urandom_range(1, 1000);
      else                cnt = $urandom;
      send_request(ts, cnt);
    end
  endtask

  task automatic test_random_with_gaps();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    send_random_packets(600);
    // Let the engine empty out completely before resuming.
    drain_results();
    repeat ($urandom_range(1, 13)) @(posedge clk);
    send_random_packets(600);
  endtask

  task automatic test_back_to_back();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    send_random_packets(200);
  endtask

  initial begin
    prev_ts = '0;
    avg_fix = '0;
    min_iv  = '1;
    max_iv  = '0;
    jit_fix = '0;
    last_iv = '0;
    stamp   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_arming_and_zero();
    test_interval_extremes();
    test_random_with_gaps();
    test_back_to_back();
    in_valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && pending_stats.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_stats.size() != 0) begin
      err_count = err_count + 1;
      $display("ERROR: %0d results never arrived", pending_stats.size());
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
